// ===== sv/gcns_pkg.sv =====
package gcns_pkg;

  localparam int POS_W     = 16;
  localparam int QUO_W     = POS_W - 1;
  localparam int IDX_W     = 10;
  localparam int CFG_W     = 16;
  localparam int GRID_RW   = 5;

  localparam int DEF_MAX_GRID_DIM  = 16;
  localparam int DEF_CELL_CAPACITY = 7;

  localparam logic [CFG_W-1:0]   RST_CELL_SIZE = 16'd256;
  localparam logic [GRID_RW-1:0] RST_GRID_DIM  = 5'd16;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  // register indexes
  localparam logic [1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [1:0] REG_GRID_COLS = 2'd1;
  localparam logic [1:0] REG_GRID_ROWS = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [IDX_W-1:0]  particle_index;
  } gcns_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] neighbor_index;
    logic             last;
  } gcns_out_t;

endpackage

// ===== sv/gcns_div.sv =====
module gcns_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [gcns_pkg::QUO_W-1:0]      dividend,
  input  logic [gcns_pkg::CFG_W-1:0]      divisor,
  output logic                            done,
  output logic [gcns_pkg::QUO_W-1:0]      quotient
);

  localparam int QW = gcns_pkg::QUO_W;
  localparam int DW = gcns_pkg::CFG_W;
  localparam int CW = $clog2(QW);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r, dvs_r;
  logic [QW-1:0] quo_r;
  logic [DW:0]   trial;
  logic          qbit;

  // one restoring step per cycle, dividend shifted out of quo_r
  assign trial = {rem_r, quo_r[QW-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvs_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= qbit ? DW'(trial - {1'b0, dvs_r}) : DW'(trial);
        quo_r <= {quo_r[QW-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/gcns_store.sv =====
module gcns_store #(
  parameter int MAX_GRID_DIM  = gcns_pkg::DEF_MAX_GRID_DIM,
  parameter int CELL_CAPACITY = gcns_pkg::DEF_CELL_CAPACITY,
  parameter int AW  = 8,
  parameter int EAW = 11,
  parameter int FW  = 3
) (
  input  logic                       clk,
  input  logic [AW-1:0]              fill_rd_addr,
  output logic [FW-1:0]              fill_rd_data,
  input  logic                       fill_we,
  input  logic [AW-1:0]              fill_wr_addr,
  input  logic [FW-1:0]              fill_wr_data,
  input  logic                       ent_re,
  input  logic [EAW-1:0]             ent_rd_addr,
  output logic [gcns_pkg::IDX_W-1:0] ent_rd_data,
  input  logic                       ent_we,
  input  logic [EAW-1:0]             ent_wr_addr,
  input  logic [gcns_pkg::IDX_W-1:0] ent_wr_data
);

  localparam int NUM_CELLS = MAX_GRID_DIM * MAX_GRID_DIM;
  localparam int NUM_ENT   = NUM_CELLS * CELL_CAPACITY;

  logic [FW-1:0]              fill_mem [NUM_CELLS];
  logic [gcns_pkg::IDX_W-1:0] ent_mem  [NUM_ENT];

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wr_addr] <= fill_wr_data;
    end
    fill_rd_data <= fill_mem[fill_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wr_addr] <= ent_wr_data;
    end
    if (ent_re) begin
      ent_rd_data <= ent_mem[ent_rd_addr];
    end
  end

endmodule

// ===== sv/grid_cell_neighbor_search.sv =====
// Flow: insert and query run the x then y division, then read the fill count of a cell;
// insert writes the entry unless the cell is full, query visits each cell of its window.
// Throughput: one item at a time; in_ready is high only while idle. Clear sweeps all
// NUM_CELLS fill counts; the two 15-step divisions (x then y, shared divider) open
// every insert and query.
// Reset (synchronous, rst_n low): registers to defaults, then a clearing pass over all
// NUM_CELLS cells zeroes the fill counts before the first beat is taken.
module grid_cell_neighbor_search #(
  parameter int MAX_GRID_DIM  = gcns_pkg::DEF_MAX_GRID_DIM,
  parameter int CELL_CAPACITY = gcns_pkg::DEF_CELL_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gcns_pkg::gcns_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gcns_pkg::gcns_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [gcns_pkg::CFG_W-1:0]    cfg_data
);

  localparam int NUM_CELLS = MAX_GRID_DIM * MAX_GRID_DIM;
  localparam int NUM_ENT   = NUM_CELLS * CELL_CAPACITY;
  localparam int AW  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int EAW = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;
  localparam int FW  = $clog2(CELL_CAPACITY + 1);
  localparam int CW  = (MAX_GRID_DIM > 1) ? $clog2(MAX_GRID_DIM) : 1;
  localparam int EW  = $clog2(MAX_GRID_DIM + 1);
  localparam int QW  = gcns_pkg::QUO_W;
  localparam int XW  = (EW > gcns_pkg::GRID_RW) ? EW : gcns_pkg::GRID_RW;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIVX = 9'b000000010,
    S_DIVY = 9'b000000100,
    S_FRD  = 9'b000001000,  // fill read issued
    S_FWT  = 9'b000010000,  // fill data valid
    S_ERD  = 9'b000100000,  // entry read issued
    S_EWT  = 9'b001000000,  // entry data valid
    S_CLR  = 9'b010000000,  // clearing sweep
    S_DONE = 9'b100000000   // final beat
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [gcns_pkg::CFG_W-1:0]   cell_size_r;
  logic [gcns_pkg::GRID_RW-1:0] grid_cols_r, grid_rows_r;

  // item context
  gcns_pkg::gcns_in_t  item_r, item_nxt;
  logic [CW-1:0]       cx_r, cx_nxt;
  logic [CW-1:0]       i_r, i_nxt, i1_r, i1_nxt;
  logic [CW-1:0]       j_r, j_nxt, j0_r, j0_nxt, j1_r, j1_nxt;
  logic [FW-1:0]       slot_r, slot_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                clr_report_r, clr_report_nxt;

  // one-deep hold so the final neighbor can carry last
  gcns_pkg::gcns_out_t held_r, held_nxt;
  logic                have_r, have_nxt;

  // output register
  gcns_pkg::gcns_out_t out_r;
  logic                out_valid_r;
  logic                push;
  gcns_pkg::gcns_out_t push_data;
  logic                out_free;

  // divider
  logic                div_start, div_done;
  logic [QW-1:0]       div_dividend, div_quo;
  logic [gcns_pkg::CFG_W-1:0] div_divisor;

  // store
  logic [AW-1:0]       cell_addr, fill_wr_addr;
  logic [FW-1:0]       fill_rd_data, fill_wr_data;
  logic                fill_we, ent_re, ent_we;
  logic [EAW-1:0]      ent_base, ent_rd_addr, ent_wr_addr;
  logic [gcns_pkg::IDX_W-1:0] ent_rd_data;

  // grid extents and axis clamp
  logic [EW-1:0]       cols, rows, ext_y;
  logic [CW-1:0]       cy;
  logic [CW-1:0]       qx_cell, qy_cell;
  logic                match, adv;

  function automatic logic [EW-1:0] extent(input logic [gcns_pkg::GRID_RW-1:0] reg_v);
    logic [EW-1:0] e;
    if (reg_v == '0) begin
      e = EW'(1);
    end else if (XW'(reg_v) > XW'(MAX_GRID_DIM)) begin
      e = EW'(MAX_GRID_DIM);
    end else begin
      e = EW'(reg_v);
    end
    return e;
  endfunction

  // quotient clamped to extent-1; negative coordinate gives 0
  function automatic logic [CW-1:0] clamp_cell(input logic [QW-1:0] q, input logic neg,
                                               input logic [EW-1:0] ext);
    logic [CW-1:0] c;
    if (neg) begin
      c = '0;
    end else if (q >= QW'(ext)) begin
      c = CW'(ext - 1'b1);
    end else begin
      c = CW'(q);
    end
    return c;
  endfunction

  assign cols = extent(grid_cols_r);
  assign rows = extent(grid_rows_r);
  assign ext_y = rows;

  assign qx_cell = clamp_cell(div_quo, item_r.pos_x[gcns_pkg::POS_W-1], cols);
  assign cy      = clamp_cell(div_quo, item_r.pos_y[gcns_pkg::POS_W-1], ext_y);
  assign qy_cell = cy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= gcns_pkg::RST_CELL_SIZE;
      grid_cols_r <= gcns_pkg::RST_GRID_DIM;
      grid_rows_r <= gcns_pkg::RST_GRID_DIM;
    end else if (cfg_we) begin
      case (cfg_index)
        gcns_pkg::REG_CELL_SIZE: cell_size_r <= cfg_data;
        gcns_pkg::REG_GRID_COLS: grid_cols_r <= cfg_data[gcns_pkg::GRID_RW-1:0];
        gcns_pkg::REG_GRID_ROWS: grid_rows_r <= cfg_data[gcns_pkg::GRID_RW-1:0];
        default: ;
      endcase
    end
  end

  // shared divider: x first, then y
  assign div_divisor  = (cell_size_r == '0) ? gcns_pkg::CFG_W'(1) : cell_size_r;
  assign div_dividend = (state_r == S_IDLE) ? QW'(in_data.pos_x) : QW'(item_r.pos_y);

  gcns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cell_addr    = AW'(i_r * MAX_GRID_DIM + j_r);
  assign ent_base     = EAW'(cell_addr * CELL_CAPACITY);
  assign ent_rd_addr  = EAW'(ent_base + slot_r);
  assign ent_wr_addr  = EAW'(ent_base + fill_rd_data);
  assign fill_wr_addr = (state_r == S_CLR) ? clr_cnt_r : cell_addr;
  assign fill_wr_data = (state_r == S_CLR) ? '0 : FW'(fill_rd_data + 1'b1);

  gcns_store #(
    .MAX_GRID_DIM  (MAX_GRID_DIM),
    .CELL_CAPACITY (CELL_CAPACITY),
    .AW            (AW),
    .EAW           (EAW),
    .FW            (FW)
  ) u_store (
    .clk          (clk),
    .fill_rd_addr (cell_addr),
    .fill_rd_data (fill_rd_data),
    .fill_we      (fill_we),
    .fill_wr_addr (fill_wr_addr),
    .fill_wr_data (fill_wr_data),
    .ent_re       (ent_re),
    .ent_rd_addr  (ent_rd_addr),
    .ent_rd_data  (ent_rd_data),
    .ent_we       (ent_we),
    .ent_wr_addr  (ent_wr_addr),
    .ent_wr_data  (item_r.particle_index)
  );

  assign out_free = !out_valid_r || out_ready;
  assign match    = (ent_rd_data != item_r.particle_index);

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    cx_nxt         = cx_r;
    i_nxt          = i_r;
    i1_nxt         = i1_r;
    j_nxt          = j_r;
    j0_nxt         = j0_r;
    j1_nxt         = j1_r;
    slot_nxt       = slot_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_report_nxt = clr_report_r;
    held_nxt       = held_r;
    have_nxt       = have_r;
    div_start      = 1'b0;
    fill_we        = 1'b0;
    ent_we         = 1'b0;
    ent_re         = 1'b0;
    push           = 1'b0;
    push_data      = held_r;
    adv            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          case (in_data.action)
            gcns_pkg::ACT_INSERT, gcns_pkg::ACT_QUERY: begin
              div_start = 1'b1;
              state_nxt = S_DIVX;
            end
            gcns_pkg::ACT_CLEAR: begin
              clr_cnt_nxt    = '0;
              clr_report_nxt = 1'b1;
              state_nxt      = S_CLR;
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      S_DIVX: begin
        if (div_done) begin
          cx_nxt    = qx_cell;
          div_start = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          have_nxt = 1'b0;
          if (item_r.action == gcns_pkg::ACT_QUERY) begin
            // 3x3 window clipped to the grid in use
            i_nxt  = (cx_r != '0) ? CW'(cx_r - 1'b1) : cx_r;
            i1_nxt = (EW'(cx_r) + 1'b1 < cols) ? CW'(cx_r + 1'b1) : CW'(cols - 1'b1);
            j0_nxt = (cy != '0) ? CW'(cy - 1'b1) : cy;
            j_nxt  = j0_nxt;
            j1_nxt = (EW'(cy) + 1'b1 < rows) ? CW'(cy + 1'b1) : CW'(rows - 1'b1);
          end else begin
            i_nxt = cx_r;
            j_nxt = qy_cell;
          end
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        state_nxt = S_FWT;
      end
      S_FWT: begin
        if (item_r.action == gcns_pkg::ACT_INSERT) begin
          if (fill_rd_data >= FW'(CELL_CAPACITY)) begin
            held_nxt = '{status: gcns_pkg::ST_FULL, neighbor_index: '0, last: 1'b0};
          end else begin
            ent_we   = 1'b1;
            fill_we  = 1'b1;
            held_nxt = '{status: gcns_pkg::ST_OK, neighbor_index: '0, last: 1'b0};
          end
          have_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else if (fill_rd_data == '0) begin
          adv = 1'b1;
        end else begin
          // newest entry sits at fill-1
          slot_nxt  = (fill_rd_data > FW'(CELL_CAPACITY)) ? FW'(CELL_CAPACITY - 1)
                                                          : FW'(fill_rd_data - 1'b1);
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        ent_re    = 1'b1;
        state_nxt = S_EWT;
      end
      S_EWT: begin
        if (!(match && have_r && !out_free)) begin
          if (match) begin
            push     = have_r;
            held_nxt = '{status: gcns_pkg::ST_OK, neighbor_index: ent_rd_data, last: 1'b0};
            have_nxt = 1'b1;
          end
          if (slot_r == '0) begin
            adv = 1'b1;
          end else begin
            slot_nxt  = slot_r - 1'b1;
            state_nxt = S_ERD;
          end
        end
      end
      S_CLR: begin
        fill_we = 1'b1;
        if (clr_cnt_r == AW'(NUM_CELLS - 1)) begin
          if (clr_report_r) begin
            held_nxt  = '{status: gcns_pkg::ST_CLEARED, neighbor_index: '0, last: 1'b0};
            have_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          push = 1'b1;
          if (have_r) begin
            push_data      = held_r;
            push_data.last = 1'b1;
          end else begin
            push_data = '{status: gcns_pkg::ST_NONE, neighbor_index: '0, last: 1'b1};
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // next cell: rows inner, columns outer
    if (adv) begin
      if (j_r == j1_r) begin
        if (i_r == i1_r) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          j_nxt     = j0_r;
          state_nxt = S_FRD;
        end
      end else begin
        j_nxt     = j_r + 1'b1;
        state_nxt = S_FRD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      have_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_report_r <= clr_report_nxt;
      have_r       <= have_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    cx_r   <= cx_nxt;
    i_r    <= i_nxt;
    i1_r   <= i1_nxt;
    j_r    <= j_nxt;
    j0_r   <= j0_nxt;
    j1_r   <= j1_nxt;
    slot_r <= slot_nxt;
    held_r <= held_nxt;
    if (push) begin
      out_r <= push_data;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
